### hdl/uhg_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the ones-complement adder of the UDP/IP header generator.
// No dependencies; every other file of the block imports this package.
package uhg_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_IP_VERSION   = 3'd0;
    localparam logic [2:0] CFG_SRC_ADDR_HI  = 3'd1;
    localparam logic [2:0] CFG_SRC_ADDR_LO  = 3'd2;
    localparam logic [2:0] CFG_DST_ADDR_HI  = 3'd3;
    localparam logic [2:0] CFG_DST_ADDR_LO  = 3'd4;
    localparam logic [2:0] CFG_PORT_PAIR    = 3'd5;
    localparam logic [2:0] CFG_TTL_HOPS     = 3'd6;
    localparam logic [2:0] CFG_OUT_CAPACITY = 3'd7;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_TOO_SMALL = 2'd2;

    // Protocol constants.
    localparam logic [7:0]  IPV4_VER_IHL   = 8'h45;
    localparam logic [7:0]  IPV6_VER       = 8'h60;
    localparam logic [15:0] IPV4_FLAGS_DF  = 16'h4000;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [17:0] IPV4_HDR_LEN   = 18'd20;
    localparam logic [17:0] IPV6_HDR_LEN   = 18'd40;
    localparam logic [17:0] UDP_HDR_LEN    = 18'd8;
    localparam logic [16:0] COUNT_MAX      = 17'h1FFFF;
    localparam logic [16:0] CAPACITY_RESET = 17'd65575;
    localparam logic [7:0]  HOP_RESET      = 8'd64;

    // Header run lengths in bytes and checksum term counts.
    localparam int unsigned HDR_BYTES_MAX = 48;
    localparam logic [5:0]  V4_RUN_LEN    = 6'd28;
    localparam logic [5:0]  V6_RUN_LEN    = 6'd48;
    localparam logic [4:0]  V4_ADDR_TERMS = 5'd4;
    localparam logic [4:0]  V6_ADDR_TERMS = 5'd16;
    localparam logic [4:0]  V4_LAST_TERM  = 5'd8;
    localparam logic [4:0]  V6_LAST_TERM  = 5'd20;

    // Configuration register file contents.
    typedef struct packed {
        logic        ip_version;
        logic [63:0] src_addr_high;
        logic [63:0] src_addr_low;
        logic [63:0] dst_addr_high;
        logic [63:0] dst_addr_low;
        logic [31:0] port_pair;
        logic [7:0]  ttl_hops;
        logic [16:0] out_capacity;
    } t_cfg;

    // One classified packet, handed from the front end to the header builder.
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] payload_sum;
        logic [15:0] udp_len;
        logic [16:0] total;
        logic [15:0] packet_id;
    } t_job;

    // Ones-complement add of two 16-bit words with end-around carry.
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

### hdl/uhg_front.sv
`timescale 1ns / 1ps
// Front end: accepts payload bytes, keeps the running checksum and byte count,
// and on the last item classifies the packet into a job. Depends on uhg_pkg.
module uhg_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  uhg_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_payload_byte,
    input  logic          i_has_byte,
    input  logic          i_end_of_payload,
    input  logic [15:0]   i_packet_id,
    output logic          o_job_valid,
    input  logic          i_job_ready,
    output uhg_pkg::t_job o_job
);
    import uhg_pkg::*;

    logic [15:0] r_sum, n_sum;
    logic [16:0] r_count, n_count;
    logic [7:0]  r_pend, n_pend;
    logic        r_odd, n_odd;

    logic        accept;
    logic [15:0] add_word;
    logic        add_en;
    logic [15:0] sum_added;
    logic [16:0] count_inc;
    logic [17:0] udp_len;
    logic [17:0] total;

    // Only the closing item of a packet needs room in the job queue.
    assign o_ready     = !i_end_of_payload || i_job_ready;
    assign accept      = i_valid && o_ready;
    assign o_job_valid = accept && i_end_of_payload;

    // One ones-complement add serves both the word pairing and the final odd-byte pad.
    always_comb begin
        if (i_has_byte) begin
            add_word = r_odd ? {r_pend, i_payload_byte} : {i_payload_byte, 8'h00};
        end else begin
            add_word = {r_pend, 8'h00};
        end
        add_en    = i_has_byte || r_odd;
        sum_added = oc_add(r_sum, add_word);
        count_inc = (i_has_byte && (r_count != COUNT_MAX)) ? r_count + 17'd1 : r_count;
    end

    // Packet classification on the last item.
    always_comb begin
        udp_len = {1'b0, count_inc} + UDP_HDR_LEN;
        total   = udp_len + (i_cfg.ip_version ? IPV6_HDR_LEN : IPV4_HDR_LEN);
        o_job.payload_sum = add_en ? sum_added : r_sum;
        o_job.udp_len     = udp_len[15:0];
        o_job.total       = total[16:0];
        o_job.packet_id   = i_packet_id;
        if (udp_len[17:16] != 2'b00) begin
            o_job.status = ST_TOO_LARGE;
        end else if ({1'b0, i_cfg.out_capacity} < total) begin
            o_job.status = ST_TOO_SMALL;
        end else begin
            o_job.status = ST_OK;
        end
    end

    // Accumulation state; every last item starts a fresh packet.
    always_comb begin
        n_sum   = r_sum;
        n_count = r_count;
        n_pend  = r_pend;
        n_odd   = r_odd;
        if (accept) begin
            if (i_end_of_payload) begin
                n_sum   = '0;
                n_count = '0;
                n_pend  = '0;
                n_odd   = 1'b0;
            end else if (i_has_byte) begin
                n_count = count_inc;
                if (r_odd) begin
                    n_sum = sum_added;
                    n_odd = 1'b0;
                end else begin
                    n_pend = i_payload_byte;
                    n_odd  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_pend  <= '0;
            r_odd   <= 1'b0;
        end else begin
            r_sum   <= n_sum;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_odd   <= n_odd;
        end
    end

endmodule

### hdl/uhg_job_fifo.sv
`timescale 1ns / 1ps
// Short job queue between the front end and the header builder.
// Depends on uhg_pkg for the job type.
module uhg_job_fifo #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  uhg_pkg::t_job i_job,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_pop,
    output uhg_pkg::t_job o_job
);
    import uhg_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_ready = (r_cnt != FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

### hdl/uhg_back.sv
`timescale 1ns / 1ps
// Header builder: sums the pseudo-header and IPv4 header one word per cycle,
// then shifts out the header run one byte per request. Depends on uhg_pkg.
module uhg_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  uhg_pkg::t_cfg i_cfg,
    input  logic          i_job_valid,
    output logic          o_job_pop,
    input  uhg_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_header_byte,
    output logic          o_end_of_header,
    output logic [1:0]    o_status,
    output logic [16:0]   o_total_length
);
    import uhg_pkg::*;

    localparam int SR_BITS = HDR_BYTES_MAX * 8;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SUM  = 4'b0010,
        S_LOAD = 4'b0100,
        S_EMIT = 4'b1000
    } t_back_state;

    t_back_state        r_state, n_state;
    t_job               r_job;
    logic [15:0]        r_usum, r_isum;
    logic [4:0]         r_term;
    logic [5:0]         r_left;
    logic [SR_BITS-1:0] r_shift;

    logic [255:0] addr_v6;
    logic [63:0]  addr_v4;
    logic [4:0]   addr_terms;
    logic [4:0]   last_term;
    logic [4:0]   extra_idx;
    logic [15:0]  udp_term;
    logic [15:0]  ip_term;
    logic [15:0]  udp_csum;
    logic [15:0]  ip_csum;
    logic [15:0]  sport, dport;
    logic [SR_BITS-1:0] hdr_bits;

    assign sport   = i_cfg.port_pair[31:16];
    assign dport   = i_cfg.port_pair[15:0];
    assign addr_v6 = {i_cfg.src_addr_high, i_cfg.src_addr_low,
                      i_cfg.dst_addr_high, i_cfg.dst_addr_low};
    assign addr_v4 = {i_cfg.src_addr_low[31:0], i_cfg.dst_addr_low[31:0]};

    // UDP checksum term of the current step: addresses first, then the fixed words.
    always_comb begin
        addr_terms = i_cfg.ip_version ? V6_ADDR_TERMS : V4_ADDR_TERMS;
        last_term  = i_cfg.ip_version ? V6_LAST_TERM : V4_LAST_TERM;
        extra_idx  = r_term - addr_terms;
        if (r_term < addr_terms) begin
            if (i_cfg.ip_version) begin
                udp_term = addr_v6[255 - 16 * r_term[3:0] -: 16];
            end else begin
                udp_term = addr_v4[63 - 16 * r_term[1:0] -: 16];
            end
        end else begin
            case (extra_idx)
                5'd0:    udp_term = {8'h00, PROTO_UDP};
                5'd1:    udp_term = r_job.udp_len;
                5'd2:    udp_term = sport;
                5'd3:    udp_term = dport;
                5'd4:    udp_term = r_job.udp_len;
                default: udp_term = 16'h0000;
            endcase
        end
    end

    // IPv4 header checksum term, checksum field itself counted as zero.
    always_comb begin
        case (r_term)
            5'd0:    ip_term = {IPV4_VER_IHL, 8'h00};
            5'd1:    ip_term = r_job.total[15:0];
            5'd2:    ip_term = r_job.packet_id;
            5'd3:    ip_term = IPV4_FLAGS_DF;
            5'd4:    ip_term = {i_cfg.ttl_hops, PROTO_UDP};
            5'd5:    ip_term = i_cfg.src_addr_low[31:16];
            5'd6:    ip_term = i_cfg.src_addr_low[15:0];
            5'd7:    ip_term = i_cfg.dst_addr_low[31:16];
            5'd8:    ip_term = i_cfg.dst_addr_low[15:0];
            default: ip_term = 16'h0000;
        endcase
    end

    // Final checksums and the header image, left aligned in the shift register.
    always_comb begin
        udp_csum = ~r_usum;
        if (udp_csum == 16'h0000) begin
            udp_csum = 16'hFFFF;
        end
        ip_csum = ~r_isum;
        if (i_cfg.ip_version) begin
            hdr_bits = {IPV6_VER, 8'h00, 16'h0000, r_job.udp_len, PROTO_UDP,
                        i_cfg.ttl_hops, addr_v6,
                        sport, dport, r_job.udp_len, udp_csum};
        end else begin
            hdr_bits = {IPV4_VER_IHL, 8'h00, r_job.total[15:0], r_job.packet_id,
                        IPV4_FLAGS_DF, i_cfg.ttl_hops, PROTO_UDP, ip_csum, addr_v4,
                        sport, dport, r_job.udp_len, udp_csum, 160'd0};
        end
    end

    // Sequencer: fetch job, sum terms, load header, emit bytes; errors go to emit.
    always_comb begin
        n_state   = r_state;
        o_job_pop = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_state   = (i_job.status == ST_OK) ? S_SUM : S_EMIT;
                end
            end
            S_SUM: begin
                if (r_term == last_term) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_ready && (r_left == 6'd1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_job_valid) begin
                r_left <= (i_job.status == ST_OK) ? 6'd0 : 6'd1;
            end else if (r_state == S_LOAD) begin
                r_left <= i_cfg.ip_version ? V6_RUN_LEN : V4_RUN_LEN;
            end else if (r_state == S_EMIT && i_ready) begin
                r_left <= r_left - 6'd1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_job   <= i_job;
                r_usum  <= i_job.payload_sum;
                r_isum  <= 16'h0000;
                r_term  <= 5'd0;
                r_shift <= '0;
            end
            S_SUM: begin
                r_usum <= oc_add(r_usum, udp_term);
                r_isum <= oc_add(r_isum, ip_term);
                r_term <= r_term + 5'd1;
            end
            S_LOAD: begin
                r_shift <= hdr_bits;
            end
            S_EMIT: begin
                if (i_ready) begin
                    r_shift <= {r_shift[SR_BITS-9:0], 8'h00};
                end
            end
            default: begin
                r_term <= 5'd0;
            end
        endcase
    end

    assign o_valid         = (r_state == S_EMIT);
    assign o_header_byte   = r_shift[SR_BITS-1 -: 8];
    assign o_end_of_header = (r_left == 6'd1);
    assign o_status        = r_job.status;
    assign o_total_length  = (r_job.status == ST_OK) ? r_job.total : 17'd0;

endmodule

### hdl/udp_ip_header_generator.sv
`timescale 1ns / 1ps
// UDP/IP header generator. Payload bytes are taken one per cycle with no stall,
// except a packet's last item when the two-entry job queue is full.
// After the last item is accepted, its job is written into the job queue; the idle
// builder then fetches it, sums the checksum terms one word per cycle and loads the
// header image before the first valid header byte goes out; error jobs skip both.
// The builder takes no new job until the previous closing request is taken.
// Synchronous active-low reset clears control state and loads register defaults.
module udp_ip_header_generator #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_has_byte,
    input  logic        i_end_of_payload,
    input  logic [15:0] i_packet_id,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_header_byte,
    output logic        o_end_of_header,
    output logic [1:0]  o_status,
    output logic [16:0] o_total_length
);
    import uhg_pkg::*;

    t_cfg r_cfg;
    t_job front_job, queue_job;
    logic job_push, queue_ready, queue_valid, job_pop;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ip_version    <= 1'b0;
            r_cfg.src_addr_high <= '0;
            r_cfg.src_addr_low  <= '0;
            r_cfg.dst_addr_high <= '0;
            r_cfg.dst_addr_low  <= '0;
            r_cfg.port_pair     <= '0;
            r_cfg.ttl_hops      <= HOP_RESET;
            r_cfg.out_capacity  <= CAPACITY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IP_VERSION:   r_cfg.ip_version    <= i_cfg_data[0];
                CFG_SRC_ADDR_HI:  r_cfg.src_addr_high <= i_cfg_data;
                CFG_SRC_ADDR_LO:  r_cfg.src_addr_low  <= i_cfg_data;
                CFG_DST_ADDR_HI:  r_cfg.dst_addr_high <= i_cfg_data;
                CFG_DST_ADDR_LO:  r_cfg.dst_addr_low  <= i_cfg_data;
                CFG_PORT_PAIR:    r_cfg.port_pair     <= i_cfg_data[31:0];
                CFG_TTL_HOPS:     r_cfg.ttl_hops      <= i_cfg_data[7:0];
                CFG_OUT_CAPACITY: r_cfg.out_capacity  <= i_cfg_data[16:0];
                default:          r_cfg.ip_version    <= r_cfg.ip_version;
            endcase
        end
    end

    // Front end: checksum accumulation and packet classification.
    uhg_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_valid          (i_in_valid),
        .o_ready          (o_in_ready),
        .i_payload_byte   (i_payload_byte),
        .i_has_byte       (i_has_byte),
        .i_end_of_payload (i_end_of_payload),
        .i_packet_id      (i_packet_id),
        .o_job_valid      (job_push),
        .i_job_ready      (queue_ready),
        .o_job            (front_job)
    );

    // Job queue between the two halves.
    uhg_job_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (front_job),
        .o_ready (queue_ready),
        .o_valid (queue_valid),
        .i_pop   (job_pop),
        .o_job   (queue_job)
    );

    // Back end: header checksums and byte output.
    uhg_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_job_valid     (queue_valid),
        .o_job_pop       (job_pop),
        .i_job           (queue_job),
        .o_valid         (o_out_valid),
        .i_ready         (i_out_ready),
        .o_header_byte   (o_header_byte),
        .o_end_of_header (o_end_of_header),
        .o_status        (o_status),
        .o_total_length  (o_total_length)
    );

    // An error result is a single closing request with zero length.
    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_end_of_header && o_total_length == 17'd0))
        else $error("error result is not a single zero-length request");

    // A good packet always carries at least both fixed headers.
    a_ok_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_OK) |-> (o_total_length >= 17'd28))
        else $error("total length below header size on a good packet");

    // Input backpressure comes only from the last item of a packet.
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (i_end_of_payload && !queue_ready))
        else $error("input stalled without a full job queue");

    // The builder goes back to fetch a job after the closing request.
    a_run_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_end_of_header) |=> !o_out_valid)
        else $error("output still valid after the closing request");

endmodule

### verif/udp_ip_header_generator_test.sv
`timescale 1ns / 1ps
// Self-checking regression for the UDP/IP header generator: streams payload requests,
// predicts every header byte and compares each result request field by field.
// Depends on uhg_pkg and udp_ip_header_generator in the hdl folder.
module udp_ip_header_generator_test;

    import uhg_pkg::*;

    localparam int unsigned STALL_LIMIT   = 5000;
    localparam int unsigned SETTLE_CYCLES = 100;
    localparam int unsigned RANDOM_ITEMS  = 390;
    localparam int unsigned PACKETS_PER_SETTING = 8;

    // One expected header result request.
    typedef struct packed {
        logic [7:0]  hbyte;
        logic        is_last;
        logic [1:0]  status;
        logic [16:0] total;
    } t_hdr_result;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_cfg_we         = 1'b0;
    logic [2:0]  i_cfg_index      = '0;
    logic [63:0] i_cfg_data       = '0;
    logic        i_in_valid       = 1'b0;
    logic [7:0]  i_payload_byte   = '0;
    logic        i_has_byte       = 1'b0;
    logic        i_end_of_payload = 1'b0;
    logic [15:0] i_packet_id      = '0;
    logic        i_out_ready      = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_header_byte;
    logic        o_end_of_header;
    logic [1:0]  o_status;
    logic [16:0] o_total_length;

    // Predictor copy of the registers and the per-packet accumulation.
    t_cfg        cfg_model;
    logic [15:0] payload_sum;
    logic [16:0] payload_count;
    logic [7:0]  held_byte;
    logic        held_valid;

    t_hdr_result header_queue[$];
    int unsigned error_count  = 0;
    int unsigned items_sent   = 0;
    int unsigned stall_cycles = 0;
    bit          idle_on      = 1'b1;

    udp_ip_header_generator u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_payload_byte   (i_payload_byte),
        .i_has_byte       (i_has_byte),
        .i_end_of_payload (i_end_of_payload),
        .i_packet_id      (i_packet_id),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_header_byte    (o_header_byte),
        .o_end_of_header  (o_end_of_header),
        .o_status         (o_status),
        .o_total_length   (o_total_length)
    );

    always #5 i_clk = ~i_clk;

    // Ones-complement accumulate of one 16-bit word, folded back to 16 bits.
    function automatic int unsigned ones_add(input int unsigned acc, input logic [15:0] word);
        int unsigned s;
        s = acc + 32'(word);
        return (s & 32'h0000FFFF) + (s >> 16);
    endfunction

    function automatic int unsigned ones_add64(input int unsigned acc, input logic [63:0] v);
        int unsigned s;
        s = ones_add(acc, v[63:48]);
        s = ones_add(s, v[47:32]);
        s = ones_add(s, v[31:16]);
        return ones_add(s, v[15:0]);
    endfunction

    // Accounts one accepted payload request and queues the header it triggers.
    function automatic void predict_headers(input logic [7:0] data, input logic has,
                                            input logic eop, input logic [15:0] pid);
        logic [383:0] hdr_bits;
        logic [159:0] ip4;
        logic [17:0]  udp_len;
        logic [17:0]  ip_len;
        logic [17:0]  total;
        logic [15:0]  udp16;
        logic [15:0]  sport;
        logic [15:0]  dport;
        logic [15:0]  csum;
        logic [1:0]   status;
        int unsigned  acc;
        int unsigned  hs;
        int unsigned  n;
        t_hdr_result  r;

        if (has) begin
            if (held_valid) begin
                payload_sum = 16'(ones_add(32'(payload_sum), {held_byte, data}));
                held_valid  = 1'b0;
            end else begin
                held_byte  = data;
                held_valid = 1'b1;
            end
            if (payload_count != COUNT_MAX)
                payload_count = payload_count + 17'd1;
        end
        if (!eop)
            return;

        // Close the packet: pad an odd byte and size the datagram.
        acc = 32'(payload_sum);
        if (held_valid)
            acc = ones_add(acc, {held_byte, 8'h00});
        udp_len = {1'b0, payload_count} + UDP_HDR_LEN;
        ip_len  = cfg_model.ip_version ? IPV6_HDR_LEN : IPV4_HDR_LEN;
        total   = ip_len + udp_len;
        payload_sum   = '0;
        payload_count = '0;
        held_byte     = '0;
        held_valid    = 1'b0;

        status = ST_OK;
        if (udp_len > 18'd65535)
            status = ST_TOO_LARGE;
        else if ({1'b0, cfg_model.out_capacity} < total)
            status = ST_TOO_SMALL;
        if (status != ST_OK) begin
            r.hbyte   = 8'h00;
            r.is_last = 1'b1;
            r.status  = status;
            r.total   = '0;
            header_queue.push_back(r);
            return;
        end

        // UDP checksum over pseudo-header, UDP header and payload.
        udp16 = udp_len[15:0];
        sport = cfg_model.port_pair[31:16];
        dport = cfg_model.port_pair[15:0];
        if (cfg_model.ip_version) begin
            acc = ones_add64(acc, cfg_model.src_addr_high);
            acc = ones_add64(acc, cfg_model.src_addr_low);
            acc = ones_add64(acc, cfg_model.dst_addr_high);
            acc = ones_add64(acc, cfg_model.dst_addr_low);
        end else begin
            acc = ones_add(acc, cfg_model.src_addr_low[31:16]);
            acc = ones_add(acc, cfg_model.src_addr_low[15:0]);
            acc = ones_add(acc, cfg_model.dst_addr_low[31:16]);
            acc = ones_add(acc, cfg_model.dst_addr_low[15:0]);
        end
        acc  = ones_add(acc, {8'd0, PROTO_UDP});
        acc  = ones_add(acc, udp16);
        acc  = ones_add(acc, sport);
        acc  = ones_add(acc, dport);
        acc  = ones_add(acc, udp16);
        csum = ~acc[15:0];
        if (csum == 16'h0000)
            csum = 16'hFFFF;

        // Assemble the header run, first byte in the top bits.
        if (cfg_model.ip_version) begin
            hdr_bits = {IPV6_VER, 24'd0, udp16, PROTO_UDP, cfg_model.ttl_hops,
                        cfg_model.src_addr_high, cfg_model.src_addr_low,
                        cfg_model.dst_addr_high, cfg_model.dst_addr_low,
                        sport, dport, udp16, csum};
        end else begin
            ip4 = {IPV4_VER_IHL, 8'h00, total[15:0], pid, IPV4_FLAGS_DF,
                   cfg_model.ttl_hops, PROTO_UDP, 16'h0000,
                   cfg_model.src_addr_low[31:0], cfg_model.dst_addr_low[31:0]};
            hs = 0;
            for (int i = 0; i < 10; i++)
                hs = ones_add(hs, ip4[159 - 16 * i -: 16]);
            ip4[79:64] = ~hs[15:0];
            hdr_bits = {ip4, sport, dport, udp16, csum, 160'd0};
        end

        n = 32'(ip_len + UDP_HDR_LEN);
        for (int i = 0; i < n; i++) begin
            r.hbyte   = hdr_bits[383 - 8 * i -: 8];
            r.is_last = (i == n - 1);
            r.status  = ST_OK;
            r.total   = total[16:0];
            header_queue.push_back(r);
        end
    endfunction

    // Result checker: every accepted result request pops the oldest expectation.
    always @(posedge i_clk) begin : check_result
        t_hdr_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (header_queue.size() == 0) begin
                $error("unexpected result request: header_byte %02h status %0d",
                       o_header_byte, o_status);
                error_count++;
            end else begin
                want = header_queue.pop_front();
                if (o_header_byte !== want.hbyte) begin
                    $error("header_byte: expected %02h, got %02h", want.hbyte, o_header_byte);
                    error_count++;
                end
                if (o_end_of_header !== want.is_last) begin
                    $error("end_of_header: expected %0b, got %0b",
                           want.is_last, o_end_of_header);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    error_count++;
                end
                if (o_total_length !== want.total) begin
                    $error("total_length: expected %0d, got %0d",
                           want.total, o_total_length);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles where neither channel moves a request.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("udp_ip_header_generator regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // With idle_on, receiver back-pressure drops ready in about 30 percent of cycles.
    always @(posedge i_clk)
        i_out_ready <= !idle_on || ($urandom_range(99) >= 30);

    // Sends one payload request, with an optional idle gap ahead of it.
    task automatic send_item(input logic [7:0] data, input logic has, input logic eop,
                             input logic [15:0] pid);
        int unsigned gap;
        gap = 0;
        if (idle_on && $urandom_range(99) < 20)
            gap = $urandom_range(3, 1);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_payload_byte   <= data;
        i_has_byte       <= has;
        i_end_of_payload <= eop;
        i_packet_id      <= pid;
        predict_headers(data, has, eop, pid);
        if (has || eop)
            items_sent++;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Sends a whole packet; fill below zero means random bytes.
    task automatic send_packet(input int unsigned len, input int fill, input bit split_end,
                               input int unsigned noise_pct, input logic [15:0] pid);
        logic [7:0] b;
        bit         is_last;
        for (int unsigned i = 0; i < len; i++) begin
            if (noise_pct != 0 && $urandom_range(99) < noise_pct)
                send_item(8'($urandom), 1'b0, 1'b0, 16'($urandom));
            b       = (fill < 0) ? 8'($urandom) : 8'(fill);
            is_last = (i == len - 1) && !split_end;
            send_item(b, 1'b1, is_last, is_last ? pid : 16'($urandom));
        end
        if (len == 0 || split_end)
            send_item(8'($urandom), 1'b0, 1'b1, pid);
    endtask

    // Stops sending and waits until every expected result has come out.
    task automatic wait_for_headers();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (header_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Writes all registers; unused upper data bits carry junk to check masking.
    task automatic write_config(input t_cfg c);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        write_reg(CFG_IP_VERSION,   {junk[63:1], c.ip_version});
        write_reg(CFG_SRC_ADDR_HI,  c.src_addr_high);
        write_reg(CFG_SRC_ADDR_LO,  c.src_addr_low);
        write_reg(CFG_DST_ADDR_HI,  c.dst_addr_high);
        write_reg(CFG_DST_ADDR_LO,  c.dst_addr_low);
        write_reg(CFG_PORT_PAIR,    {junk[63:32], c.port_pair});
        write_reg(CFG_TTL_HOPS,     {junk[63:8], c.ttl_hops});
        write_reg(CFG_OUT_CAPACITY, {junk[63:17], c.out_capacity});
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        cfg_model = c;
    endtask

    function automatic t_cfg random_config();
        t_cfg c;
        c.ip_version    = 1'($urandom_range(1, 0));
        c.src_addr_high = {$urandom, $urandom};
        c.src_addr_low  = {$urandom, $urandom};
        c.dst_addr_high = {$urandom, $urandom};
        c.dst_addr_low  = {$urandom, $urandom};
        c.port_pair     = $urandom;
        c.ttl_hops      = 8'($urandom);
        if ($urandom_range(99) < 20)
            c.out_capacity = 17'($urandom_range(60, 28));
        else
            c.out_capacity = CAPACITY_RESET;
        return c;
    endfunction

    // Register defaults after reset: empty, odd and even payloads, an ignored request.
    task automatic test_reset_defaults();
        send_packet(0, -1, 1'b0, 0, 16'h0000);
        send_packet(1, 255, 1'b0, 0, 16'hFFFF);
        send_item(8'hA5, 1'b0, 1'b0, 16'h1234);
        send_packet(2, -1, 1'b0, 0, 16'h8001);
        wait_for_headers();
    endtask

    // IPv4, top-value registers but default capacity, and a checksum folding to zero.
    task automatic test_ipv4_extremes();
        t_cfg        c;
        int unsigned acc;
        logic [15:0] word;
        c              = '1;
        c.ip_version   = 1'b0;
        c.out_capacity = CAPACITY_RESET;
        write_config(c);
        send_packet(3, 255, 1'b0, 0, 16'hFFFF);
        send_packet(2, 0, 1'b1, 0, 16'h0000);

        // A two-byte payload that cancels the rest of the sum, so the computed
        // checksum is zero and must go out as all ones.
        c.port_pair = 32'h1F40_0035;
        c.dst_addr_low = 64'h0000_0000_C0A8_0001;
        wait_for_headers();
        write_config(c);
        acc = 0;
        acc = ones_add(acc, c.src_addr_low[31:16]);
        acc = ones_add(acc, c.src_addr_low[15:0]);
        acc = ones_add(acc, c.dst_addr_low[31:16]);
        acc = ones_add(acc, c.dst_addr_low[15:0]);
        acc = ones_add(acc, {8'd0, PROTO_UDP});
        acc = ones_add(acc, 16'd10);
        acc = ones_add(acc, c.port_pair[31:16]);
        acc = ones_add(acc, c.port_pair[15:0]);
        acc = ones_add(acc, 16'd10);
        word = ~acc[15:0];
        send_item(word[15:8], 1'b1, 1'b0, 16'($urandom));
        send_item(word[7:0], 1'b1, 1'b1, 16'h5A5A);
        wait_for_headers();
    endtask

    // IPv6 with all-ones and all-zero settings.
    task automatic test_ipv6_extremes();
        t_cfg c;
        c              = '1;
        c.out_capacity = CAPACITY_RESET;
        write_config(c);
        send_packet(1, 255, 1'b0, 0, 16'($urandom));
        send_packet(4, 255, 1'b0, 0, 16'($urandom));
        wait_for_headers();
        c            = '0;
        c.ip_version = 1'b1;
        c.out_capacity = CAPACITY_RESET;
        write_config(c);
        send_packet(0, -1, 1'b0, 0, 16'($urandom));
        send_packet(5, 0, 1'b1, 0, 16'($urandom));
        wait_for_headers();
    endtask

    // Capacity exactly at, one below and far below the packet size, then far above.
    task automatic test_capacity_limits();
        t_cfg c;
        c              = random_config();
        c.ip_version   = 1'b0;
        c.out_capacity = 17'd33;
        write_config(c);
        send_packet(5, -1, 1'b0, 0, 16'($urandom));
        send_packet(6, -1, 1'b0, 0, 16'($urandom));
        wait_for_headers();
        c.out_capacity = '0;
        write_config(c);
        send_packet(0, -1, 1'b0, 0, 16'($urandom));
        wait_for_headers();
        c.ip_version   = 1'b1;
        c.out_capacity = '1;
        write_config(c);
        send_packet(3, -1, 1'b0, 0, 16'($urandom));
        wait_for_headers();
    endtask

    // Back-to-back packets with no idling on either side: a long payload, then a run
    // of empty packets that fills the job queue, then a packet with a split end mark.
    task automatic test_no_idle_burst();
        t_cfg c;
        idle_on        = 1'b0;
        c              = random_config();
        c.out_capacity = CAPACITY_RESET;
        write_config(c);
        send_packet(40, -1, 1'b0, 0, 16'($urandom));
        for (int k = 0; k < 6; k++)
            send_packet(0, -1, 1'b0, 0, 16'($urandom));
        send_packet(3, -1, 1'b1, 0, 16'($urandom));
        wait_for_headers();
        idle_on = 1'b1;
    endtask

    // Random packets under random settings, with noise and occasional full drains.
    task automatic test_random_traffic();
        int unsigned start_items;
        int unsigned pkt;
        int unsigned len;
        start_items = items_sent;
        pkt = 0;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            if (pkt % PACKETS_PER_SETTING == 0) begin
                wait_for_headers();
                write_config(random_config());
            end else if ($urandom_range(99) < 8) begin
                wait_for_headers();
            end
            if ($urandom_range(99) < 90)
                len = $urandom_range(12, 0);
            else
                len = $urandom_range(64, 13);
            send_packet(len, -1, $urandom_range(99) < 20,
                        ($urandom_range(99) < 10) ? 15 : 0, 16'($urandom));
            pkt++;
        end
        wait_for_headers();
    endtask

    initial begin
        cfg_model               = '0;
        cfg_model.ttl_hops      = HOP_RESET;
        cfg_model.out_capacity  = CAPACITY_RESET;
        payload_sum             = '0;
        payload_count           = '0;
        held_byte               = '0;
        held_valid              = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_ipv4_extremes();
        test_ipv6_extremes();
        test_capacity_limits();
        test_no_idle_burst();
        test_random_traffic();

        if (error_count == 0)
            $display("udp_ip_header_generator regression: pass");
        else
            $display("udp_ip_header_generator regression: fail");
        $finish;
    end

endmodule

### filelist.f
hdl/uhg_pkg.sv
hdl/uhg_front.sv
hdl/uhg_job_fifo.sv
hdl/uhg_back.sv
hdl/udp_ip_header_generator.sv
verif/udp_ip_header_generator_test.sv
